@@ rtl/nls_pkg.sv @@
// nls_pkg: shared types and constants of the nearest light selector.
// Used by nls_dist, nls_ram users and nearest_light_selector; no dependencies.

package nls_pkg;

    localparam int MAX_KEEP  = 32;
    localparam int KEEP_AW   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CNT_W     = $clog2(MAX_KEEP + 1);

    localparam int IDX_W     = 10;
    localparam int RANK_W    = 5;
    localparam int COORD_W   = 24;
    localparam int MAG_W     = COORD_W;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int KEY_W     = PROD_W + 2;
    localparam int CFG_W     = 24;
    localparam int ML_W      = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CMP_W     = (CNT_W > ML_W) ? CNT_W : ML_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_X      = 3'd0,
        CFG_QUERY_Y      = 3'd1,
        CFG_QUERY_Z      = 3'd2,
        CFG_MAX_DISTANCE = 3'd3,
        CFG_MAX_LIGHTS   = 3'd4
    } cfg_reg_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIST,
        S_BEGIN,
        S_CMP,
        S_WR0,
        S_EMIT_RD,
        S_EMIT_LD
    } state_e;

    typedef struct packed {
        logic [IDX_W-1:0]          light_index;
        logic                      is_directional;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      last_light;
    } light_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  selected_index;
        logic [RANK_W-1:0] rank;
        logic              none_selected;
        logic              last_out;
    } light_out_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             done;
        logic             keep;
        logic [KEY_W-1:0] key;
    } dist_res_t;

endpackage

@@ rtl/nls_ram.sv @@
// nls_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.

module nls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/nls_dist.sv @@
// nls_dist: squared distance and inclusion test over one shared 24x24 multiplier.
// Depends on nls_pkg.

module nls_dist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [nls_pkg::COORD_W-1:0] pos_x,
    input  logic signed [nls_pkg::COORD_W-1:0] pos_y,
    input  logic signed [nls_pkg::COORD_W-1:0] pos_z,
    input  logic signed [nls_pkg::COORD_W-1:0] query_x,
    input  logic signed [nls_pkg::COORD_W-1:0] query_y,
    input  logic signed [nls_pkg::COORD_W-1:0] query_z,
    input  logic [nls_pkg::CFG_W-1:0]          max_distance,
    output nls_pkg::dist_res_t                 res
);

    localparam int DW = nls_pkg::COORD_W + 1;

    logic                        run_reg, run_next;
    logic [2:0]                  step_reg, step_next;
    logic [nls_pkg::PROD_W-1:0]  prod_reg;
    logic [nls_pkg::KEY_W-1:0]   acc_reg, acc_next;
    logic signed [nls_pkg::COORD_W-1:0] pa, qa;
    logic signed [DW-1:0]        diff;
    logic [DW-1:0]               diff_abs;
    logic [nls_pkg::MAG_W-1:0]   oper;

    always_comb
    begin
        unique case (step_reg)
            3'd0:    begin pa = pos_x; qa = query_x; end
            3'd1:    begin pa = pos_y; qa = query_y; end
            default: begin pa = pos_z; qa = query_z; end
        endcase
        diff     = DW'(pa) - DW'(qa);
        diff_abs = diff[DW-1] ? DW'(-diff) : DW'(diff);
        oper     = (step_reg == 3'd3) ? max_distance : diff_abs[nls_pkg::MAG_W-1:0];
    end

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = 3'd0;
            acc_next  = '0;
        end
        else if (run_reg)
        begin
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd4)
            begin
                run_next = 1'b0;
            end
            if (step_reg != 3'd0 && step_reg != 3'd4)
            begin
                acc_next = acc_reg + nls_pkg::KEY_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= oper * oper;
    end

    // after step 3 prod_reg holds max_distance squared
    assign res.done = run_reg && (step_reg == 3'd4);
    assign res.key  = acc_reg;
    assign res.keep = (acc_reg <= nls_pkg::KEY_W'(prod_reg));

endmodule

@@ rtl/nearest_light_selector.sv @@
// nearest_light_selector: keeps the nearest lights of a run in a sorted RAM.
// Depends on nls_pkg, nls_ram and nls_dist.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, in_item               | light item in
//  out     | out_valid, out_ready, out_item            | selected light out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// Per item: accept and load, then the distance unit on a positional light; a kept
// light then takes a begin step, a walk over kept entries (up to kept count) and a
// head write when it lands at the head; the walk shares the single RAM port pair.
// Last item: each result takes a RAM read and an output load; empty run: a load only.
// Reset empties the store; RAM contents need no clearing.
// A stalled output pauses emission; input is taken again once the last result loads.

module nearest_light_selector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  nls_pkg::light_in_t                in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output nls_pkg::light_out_t               out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nls_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW  = nls_pkg::KEEP_AW;
    localparam int CW  = nls_pkg::CNT_W;

    nls_pkg::state_e    state_reg, state_next;
    nls_pkg::light_in_t item_reg;

    logic signed [nls_pkg::COORD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [nls_pkg::CFG_W-1:0]          maxd_reg;
    logic [nls_pkg::ML_W-1:0]           ml_reg;

    logic [nls_pkg::KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]             kept_reg, kept_next;
    logic [AW-1:0]             ptr_reg, ptr_next;
    logic [CW-1:0]             k_reg, k_next;

    logic                      out_valid_reg, out_valid_next;
    nls_pkg::light_out_t       out_item_reg, out_item_next;
    logic                      out_load;
    logic                      out_free;

    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    nls_pkg::entry_t           ram_wdata, ram_rdata, new_entry;

    logic                      dist_start;
    nls_pkg::dist_res_t        dist_res;

    logic [CW-1:0]             dst;
    logic                      gt;
    logic                      dst_ok;
    logic                      not_full;
    logic [nls_pkg::CMP_W-1:0] emit_n;
    logic                      emit_last;
    nls_pkg::state_e           fin_state;

    assign in_ready  = (state_reg == nls_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg   <= '0;
            qy_reg   <= '0;
            qz_reg   <= '0;
            maxd_reg <= '0;
            ml_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                nls_pkg::CFG_QUERY_X:      qx_reg   <= cfg_data;
                nls_pkg::CFG_QUERY_Y:      qy_reg   <= cfg_data;
                nls_pkg::CFG_QUERY_Z:      qz_reg   <= cfg_data;
                nls_pkg::CFG_MAX_DISTANCE: maxd_reg <= cfg_data;
                nls_pkg::CFG_MAX_LIGHTS:   ml_reg   <= cfg_data[nls_pkg::ML_W-1:0];
                default:                   ;
            endcase
        end
    end

    nls_dist u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (dist_start),
        .pos_x        (item_reg.pos_x),
        .pos_y        (item_reg.pos_y),
        .pos_z        (item_reg.pos_z),
        .query_x      (qx_reg),
        .query_y      (qy_reg),
        .query_z      (qz_reg),
        .max_distance (maxd_reg),
        .res          (dist_res)
    );

    nls_ram #(
        .WIDTH (nls_pkg::ENTRY_W),
        .DEPTH (nls_pkg::MAX_KEEP)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign new_entry.key = key_reg;
    assign new_entry.idx = item_reg.light_index;

    assign dst      = CW'(ptr_reg) + CW'(1);
    assign gt       = ram_rdata.key > key_reg;
    assign dst_ok   = dst < CW'(nls_pkg::MAX_KEEP);
    assign not_full = kept_reg < CW'(nls_pkg::MAX_KEEP);

    assign emit_n = ((ml_reg != '0) && (nls_pkg::CMP_W'(ml_reg) < nls_pkg::CMP_W'(kept_reg)))
                    ? nls_pkg::CMP_W'(ml_reg) : nls_pkg::CMP_W'(kept_reg);
    assign emit_last = (nls_pkg::CMP_W'(k_reg) + nls_pkg::CMP_W'(1)) == emit_n;

    assign fin_state = item_reg.last_light ? nls_pkg::S_EMIT_RD : nls_pkg::S_IDLE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nls_pkg::S_IDLE:
                if (in_valid)
                begin
                    state_next = nls_pkg::S_LOAD;
                end
            nls_pkg::S_LOAD:
                state_next = item_reg.is_directional ? nls_pkg::S_BEGIN : nls_pkg::S_DIST;
            nls_pkg::S_DIST:
                if (dist_res.done)
                begin
                    state_next = dist_res.keep ? nls_pkg::S_BEGIN : fin_state;
                end
            nls_pkg::S_BEGIN:
                state_next = (kept_reg == '0) ? fin_state : nls_pkg::S_CMP;
            nls_pkg::S_CMP:
                if (gt)
                begin
                    state_next = (ptr_reg == '0) ? nls_pkg::S_WR0 : nls_pkg::S_CMP;
                end
                else
                begin
                    state_next = fin_state;
                end
            nls_pkg::S_WR0:
                state_next = fin_state;
            nls_pkg::S_EMIT_RD:
                if (out_free)
                begin
                    state_next = (kept_reg == '0) ? nls_pkg::S_IDLE : nls_pkg::S_EMIT_LD;
                end
            nls_pkg::S_EMIT_LD:
                state_next = emit_last ? nls_pkg::S_IDLE : nls_pkg::S_EMIT_RD;
            default:
                state_next = nls_pkg::S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        key_next      = key_reg;
        kept_next     = kept_reg;
        ptr_next      = ptr_reg;
        k_next        = '0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = new_entry;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        dist_start    = 1'b0;
        out_load      = 1'b0;
        out_item_next = out_item_reg;
        unique case (state_reg)
            nls_pkg::S_IDLE:
                ;
            nls_pkg::S_LOAD:
            begin
                key_next   = '0;
                dist_start = !item_reg.is_directional;
            end
            nls_pkg::S_DIST:
                if (dist_res.done)
                begin
                    key_next = dist_res.key;
                end
            nls_pkg::S_BEGIN:
                if (kept_reg == '0)
                begin
                    ram_we    = 1'b1;
                    kept_next = kept_reg + CW'(1);
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(kept_reg - CW'(1));
                    ptr_next  = AW'(kept_reg - CW'(1));
                end
            nls_pkg::S_CMP:
                if (gt)
                begin
                    // shift the larger entry up one place; dropped past the end
                    ram_we    = dst_ok;
                    ram_waddr = dst[AW-1:0];
                    ram_wdata = ram_rdata;
                    if (ptr_reg != '0)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg - AW'(1);
                        ptr_next  = ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    ram_we    = dst_ok;
                    ram_waddr = dst[AW-1:0];
                    if (not_full)
                    begin
                        kept_next = kept_reg + CW'(1);
                    end
                end
            nls_pkg::S_WR0:
            begin
                ram_we = 1'b1;
                if (not_full)
                begin
                    kept_next = kept_reg + CW'(1);
                end
            end
            nls_pkg::S_EMIT_RD:
            begin
                k_next = k_reg;
                if (out_free)
                begin
                    if (kept_reg == '0)
                    begin
                        out_load                     = 1'b1;
                        out_item_next.selected_index = '0;
                        out_item_next.rank           = '0;
                        out_item_next.none_selected  = 1'b1;
                        out_item_next.last_out       = 1'b1;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = k_reg[AW-1:0];
                    end
                end
            end
            nls_pkg::S_EMIT_LD:
            begin
                out_load                     = 1'b1;
                out_item_next.selected_index = ram_rdata.idx;
                out_item_next.rank           = nls_pkg::RANK_W'(k_reg);
                out_item_next.none_selected  = 1'b0;
                out_item_next.last_out       = emit_last;
                if (emit_last)
                begin
                    kept_next = '0;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                end
            end
            default:
                ;
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nls_pkg::S_IDLE;
            kept_reg      <= '0;
            ptr_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kept_reg      <= kept_next;
            ptr_reg       <= ptr_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        key_reg      <= key_next;
        out_item_reg <= out_item_next;
    end

`ifndef NO_ASSERTIONS
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= CW'(nls_pkg::MAX_KEEP))
        else $error("kept count above store capacity");

    a_ptr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nls_pkg::S_CMP) |-> (CW'(ptr_reg) < kept_reg))
        else $error("insertion walk outside kept entries");

    a_dist_done: assert property (@(posedge clk) disable iff (!rst_n)
        dist_res.done |-> (state_reg == nls_pkg::S_DIST))
        else $error("distance result outside distance wait");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == nls_pkg::S_EMIT_LD
                                  || $past(state_reg) == nls_pkg::S_EMIT_RD))
        else $error("output item loaded outside emission");

    a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nls_pkg::S_EMIT_RD || state_reg == nls_pkg::S_EMIT_LD) |-> !ram_we)
        else $error("store written during emission");
`endif

endmodule
